[hdl/sfau_pkg.sv]
// Shared types, codes and constants of the single-precision arithmetic unit.
// Depends on nothing; every other file of the unit imports it.
package sfau_pkg;

  localparam int DIV_STAGES = 6;
  localparam int DIV_STEP   = 5;
  localparam int QUO_W      = DIV_STAGES * DIV_STEP;
  localparam int LATENCY    = 1 + DIV_STAGES + 3;

  typedef logic [31:0]        word_t;
  typedef logic signed [10:0] sexp_t;

  localparam word_t SGN_BIT   = 32'h8000_0000;
  localparam word_t EXP_ALL   = 32'h7F80_0000;
  localparam word_t CANON_NAN = 32'h7FC0_0000;
  localparam word_t QUIET_BIT = 32'h0040_0000;
  localparam logic [7:0] EXP_TOP   = 8'hFF;
  localparam logic [7:0] BIAS      = 8'd127;
  localparam logic [7:0] SINT_TOP  = 8'd158;
  localparam logic [7:0] UINT_TOP  = 8'd159;
  localparam logic [7:0] I2F_EXP   = 8'd158;

  typedef enum logic [3:0] {
    OP_ADD    = 4'd0,
    OP_SUB    = 4'd1,
    OP_MUL    = 4'd2,
    OP_DIV    = 4'd3,
    OP_NEG    = 4'd4,
    OP_SINT2F = 4'd5,
    OP_UINT2F = 4'd6,
    OP_F2SINT = 4'd7,
    OP_F2UINT = 4'd8,
    OP_CMP    = 4'd9
  } op_e;

  typedef enum logic [1:0] {
    ORD_LESS    = 2'd0,
    ORD_EQUAL   = 2'd1,
    ORD_GREATER = 2'd2,
    ORD_UNORD   = 2'd3
  } ord_e;

  typedef enum logic [2:0] {
    K_DIRECT,
    K_ADD,
    K_MUL,
    K_DIV,
    K_I2F
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    word_t       res;
    ord_e        ord;
    logic        sign;
    logic        eff_sub;
    sexp_t       e0;
    word_t       ma;
    logic [29:0] mb;
  } prep_t;

  typedef struct packed {
    kind_e kind;
    word_t res;
    ord_e  ord;
    logic  sign;
    sexp_t e0;
    word_t m;
  } mid_t;

endpackage

[hdl/single_float_arith_unit.sv]
// Top level of the single-precision arithmetic unit: decode, mantissa datapath,
// divider and rounding pipeline. Depends on sfau_pkg, sfau_prep, sfau_div, sfau_norm.
//
// Usage: drive op_i, operand_a_i and operand_b_i with start high; the request is
// taken at that edge whenever busy is low, and busy stays low at all times, so a
// new request may be issued on every clock.
// Every request gives exactly one result. It appears on result_bits_o and order_o
// with done_o high, in request order. Throughput is one request per cycle for every
// operation; the pipeline holds one decode stage, the six-stage divider (five
// quotient bits per stage) and three normalise/round stages, and all operations
// share it.
// Results cannot be held off: the receiver must take each one as it is shown.
// Reset clears the valid bits of every stage; requests in flight are dropped and
// no result appears until a new request has passed through.
module single_float_arith_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  logic [3:0]      op_i,
  input  sfau_pkg::word_t operand_a_i,
  input  sfau_pkg::word_t operand_b_i,
  output logic            done_o,
  output sfau_pkg::word_t result_bits_o,
  output logic [1:0]      order_o
);
  import sfau_pkg::*;

  localparam int DLY = DIV_STAGES - 2;

  typedef struct packed {
    kind_e       kind;
    word_t       res;
    ord_e        ord;
    logic        sign;
    sexp_t       e0;
    logic [47:0] p;
  } prod_t;

  logic  v1, v2_q, v3_q;
  logic  dly_v_q [DLY];
  prep_t s1;
  prod_t s2_d, s2_q;
  mid_t  s3_d, s3_q, mid_sel;
  mid_t  dly_q [DLY];
  word_t div_m;

  assign busy = 1'b0;

  sfau_prep u_prep (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (start && !busy),
    .op_i     (op_i),
    .a_i      (operand_a_i),
    .b_i      (operand_b_i),
    .valid_o  (v1),
    .prep_o   (s1)
  );

  sfau_div u_div (
    .clk_i (clk_i),
    .rem_i (s1.ma[23:0]),
    .dsr_i (s1.mb[23:0]),
    .m_o   (div_m)
  );

  always_comb begin
    s2_d.kind = s1.kind;
    s2_d.res  = s1.res;
    s2_d.ord  = s1.ord;
    s2_d.sign = s1.sign;
    s2_d.e0   = s1.e0;
    case (s1.kind)
      K_ADD: begin
        s2_d.p = {16'b0, s1.eff_sub ? (s1.ma - {2'b0, s1.mb}) : (s1.ma + {2'b0, s1.mb})};
      end
      K_MUL: begin
        s2_d.p = s1.ma[23:0] * s1.mb[23:0];
      end
      default: begin
        s2_d.p = {16'b0, s1.ma};
      end
    endcase
  end

  always_comb begin
    s3_d.kind = s2_q.kind;
    s3_d.res  = s2_q.res;
    s3_d.ord  = s2_q.ord;
    s3_d.sign = s2_q.sign;
    s3_d.e0   = s2_q.e0;
    s3_d.m    = s2_q.p[31:0];
    if (s2_q.kind == K_MUL) begin
      if (s2_q.p[47]) begin
        s3_d.m  = s2_q.p[47:16] | {31'b0, (s2_q.p[15:0] != '0)};
        s3_d.e0 = s2_q.e0 + sexp_t'(1);
      end else begin
        s3_d.m  = s2_q.p[46:15] | {31'b0, (s2_q.p[14:0] != '0)};
      end
    end
  end

  always_comb begin
    mid_sel = dly_q[DLY-1];
    if (mid_sel.kind == K_DIV) begin
      mid_sel.m = div_m;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      for (int k = 0; k < DLY; k++) begin
        dly_v_q[k] <= 1'b0;
      end
    end else begin
      v2_q       <= v1;
      v3_q       <= v2_q;
      dly_v_q[0] <= v3_q;
      for (int k = 1; k < DLY; k++) begin
        dly_v_q[k] <= dly_v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s2_q     <= s2_d;
    s3_q     <= s3_d;
    dly_q[0] <= s3_q;
    for (int k = 1; k < DLY; k++) begin
      dly_q[k] <= dly_q[k-1];
    end
  end

  sfau_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dly_v_q[DLY-1]),
    .mid_i   (mid_sel),
    .valid_o (done_o),
    .res_o   (result_bits_o),
    .ord_o   (order_o)
  );

  a_done_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LATENCY done_o)
    else $error("request without result");

  a_neg_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && op_i == OP_NEG) |-> ##LATENCY
      (result_bits_o == ($past(operand_a_i, LATENCY) ^ SGN_BIT)))
    else $error("negate result wrong");

  a_order_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && op_i != OP_CMP) |-> ##LATENCY (order_o == ORD_LESS))
    else $error("order set on non-compare result");

endmodule

[hdl/sfau_prep.sv]
// Operand decode stage: special cases, direct results, add alignment, divider seed.
// Depends on sfau_pkg.
module sfau_prep (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [3:0]        op_i,
  input  sfau_pkg::word_t   a_i,
  input  sfau_pkg::word_t   b_i,
  output logic              valid_o,
  output sfau_pkg::prep_t   prep_o
);
  import sfau_pkg::*;

  word_t       y_add, x_add, z_add, sgn_ab, v_int;
  logic        swap, nan_a, nan_b;
  logic [7:0]  ex_x, ex_z, d_add, ea, eb, sh;
  logic [29:0] mx, mz, mz_sh, mz_al;
  logic [23:0] ma, mb;
  logic [24:0] ma_sh, rem_w;
  logic [54:0] wide;
  logic signed [31:0] key_a, key_b;
  prep_t       prep_d, prep_q;
  logic        valid_q;

  always_comb begin
    y_add = (op_e'(op_i) == OP_SUB) ? (b_i ^ SGN_BIT) : b_i;
    swap  = a_i[30:0] < y_add[30:0];
    x_add = swap ? y_add : a_i;
    z_add = swap ? a_i : y_add;
    ex_x  = x_add[30:23];
    ex_z  = z_add[30:23];
    mx    = {1'b1, x_add[22:0], 6'b0};
    mz    = (ex_z != 8'd0) ? {1'b1, z_add[22:0], 6'b0} : '0;
    d_add = ex_x - ex_z;
    mz_sh = mz >> d_add[4:0];
    if (d_add > 8'd30) begin
      mz_al = {29'b0, |mz};
    end else begin
      mz_al = mz_sh | {29'b0, ((mz_sh << d_add[4:0]) != mz)};
    end
  end

  always_comb begin
    ea     = a_i[30:23];
    eb     = b_i[30:23];
    ma     = {1'b1, a_i[22:0]};
    mb     = {1'b1, b_i[22:0]};
    sgn_ab = (a_i ^ b_i) & SGN_BIT;
    ma_sh  = (ma < mb) ? {ma, 1'b0} : {1'b0, ma};
    rem_w  = ma_sh - {1'b0, mb};
    sh     = ea - BIAS;
    wide   = {31'b0, ma} << sh[4:0];
    v_int  = wide[54:23];
    nan_a  = a_i[30:0] > EXP_ALL[30:0];
    nan_b  = b_i[30:0] > EXP_ALL[30:0];
    key_a  = (ea == 8'd0) ? '0 : (a_i[31] ? -$signed({1'b0, a_i[30:0]})
                                          : $signed({1'b0, a_i[30:0]}));
    key_b  = (eb == 8'd0) ? '0 : (b_i[31] ? -$signed({1'b0, b_i[30:0]})
                                          : $signed({1'b0, b_i[30:0]}));
  end

  always_comb begin
    prep_d      = '0;
    prep_d.kind = K_DIRECT;
    prep_d.ord  = ORD_LESS;
    case (op_e'(op_i))
      OP_ADD, OP_SUB: begin
        if (ex_x == EXP_TOP) begin
          if (x_add[22:0] == '0 && ex_z == EXP_TOP && z_add[22:0] == '0 &&
              x_add[31] != z_add[31]) begin
            prep_d.res = CANON_NAN;
          end else if (x_add[22:0] != '0) begin
            prep_d.res = x_add | QUIET_BIT;
          end else begin
            prep_d.res = x_add;
          end
        end else if (ex_x == 8'd0) begin
          prep_d.res = {x_add[31] & z_add[31], 31'b0};
        end else begin
          prep_d.kind    = K_ADD;
          prep_d.sign    = x_add[31];
          prep_d.eff_sub = x_add[31] ^ z_add[31];
          prep_d.e0      = sexp_t'({3'b0, ex_x}) + sexp_t'(2);
          prep_d.ma      = {2'b0, mx};
          prep_d.mb      = mz_al;
        end
      end
      OP_MUL: begin
        if (ea == EXP_TOP || eb == EXP_TOP) begin
          if ((ea == EXP_TOP && a_i[22:0] != '0) || (eb == EXP_TOP && b_i[22:0] != '0)) begin
            prep_d.res = CANON_NAN;
          end else if ((ea == EXP_TOP && eb == 8'd0) || (eb == EXP_TOP && ea == 8'd0)) begin
            prep_d.res = CANON_NAN;
          end else begin
            prep_d.res = sgn_ab | EXP_ALL;
          end
        end else if (ea == 8'd0 || eb == 8'd0) begin
          prep_d.res = sgn_ab;
        end else begin
          prep_d.kind = K_MUL;
          prep_d.sign = sgn_ab[31];
          prep_d.e0   = sexp_t'({3'b0, ea}) + sexp_t'({3'b0, eb}) - sexp_t'({3'b0, BIAS});
          prep_d.ma   = {8'b0, ma};
          prep_d.mb   = {6'b0, mb};
        end
      end
      OP_DIV: begin
        if (ea == EXP_TOP) begin
          prep_d.res = (a_i[22:0] != '0 || eb == EXP_TOP) ? CANON_NAN : (sgn_ab | EXP_ALL);
        end else if (eb == EXP_TOP) begin
          prep_d.res = (b_i[22:0] != '0) ? CANON_NAN : sgn_ab;
        end else if (eb == 8'd0) begin
          prep_d.res = (ea == 8'd0) ? CANON_NAN : (sgn_ab | EXP_ALL);
        end else if (ea == 8'd0) begin
          prep_d.res = sgn_ab;
        end else begin
          prep_d.kind = K_DIV;
          prep_d.sign = sgn_ab[31];
          prep_d.e0   = sexp_t'({3'b0, ea}) - sexp_t'({3'b0, eb}) + sexp_t'({3'b0, BIAS})
                        - sexp_t'({10'b0, (ma < mb)});
          prep_d.ma   = {8'b0, rem_w[23:0]};
          prep_d.mb   = {6'b0, mb};
        end
      end
      OP_NEG: begin
        prep_d.res = a_i ^ SGN_BIT;
      end
      OP_SINT2F: begin
        prep_d.kind = K_I2F;
        prep_d.sign = a_i[31];
        prep_d.e0   = sexp_t'({3'b0, I2F_EXP});
        prep_d.ma   = a_i[31] ? (32'd0 - a_i) : a_i;
      end
      OP_UINT2F: begin
        prep_d.kind = K_I2F;
        prep_d.e0   = sexp_t'({3'b0, I2F_EXP});
        prep_d.ma   = a_i;
      end
      OP_F2SINT: begin
        if (ea < BIAS) begin
          prep_d.res = '0;
        end else if (ea >= SINT_TOP) begin
          prep_d.res = a_i[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
          prep_d.res = a_i[31] ? (32'd0 - v_int) : v_int;
        end
      end
      OP_F2UINT: begin
        if (a_i[31] || ea < BIAS) begin
          prep_d.res = '0;
        end else if (ea >= UINT_TOP) begin
          prep_d.res = 32'hFFFF_FFFF;
        end else begin
          prep_d.res = v_int;
        end
      end
      OP_CMP: begin
        if (nan_a || nan_b) begin
          prep_d.ord = ORD_UNORD;
        end else if (key_a < key_b) begin
          prep_d.ord = ORD_LESS;
        end else if (key_a > key_b) begin
          prep_d.ord = ORD_GREATER;
        end else begin
          prep_d.ord = ORD_EQUAL;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prep_q <= prep_d;
  end

  assign valid_o = valid_q;
  assign prep_o  = prep_q;

endmodule

[hdl/sfau_div.sv]
// Pipelined restoring mantissa divider, DIV_STEP quotient bits in each of the DIV_STAGES stages.
// Depends on sfau_pkg.
module sfau_div (
  input  logic            clk_i,
  input  logic [23:0]     rem_i,
  input  logic [23:0]     dsr_i,
  output sfau_pkg::word_t m_o
);
  import sfau_pkg::*;

  logic [23:0]      rem_q [DIV_STAGES];
  logic [23:0]      dsr_q [DIV_STAGES];
  logic [QUO_W-1:0] quo_q [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [23:0]      rem_in, dsr_in, rem_d;
    logic [QUO_W-1:0] quo_in, quo_d;

    if (k == 0) begin : g_first
      assign rem_in = rem_i;
      assign dsr_in = dsr_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign dsr_in = dsr_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    always_comb begin
      logic [24:0] r2, diff;
      rem_d = rem_in;
      quo_d = quo_in;
      for (int j = 0; j < DIV_STEP; j++) begin
        r2   = {rem_d, 1'b0};
        diff = r2 - {1'b0, dsr_in};
        if (r2 >= {1'b0, dsr_in}) begin
          rem_d = diff[23:0];
          quo_d = {quo_d[QUO_W-2:0], 1'b1};
        end else begin
          rem_d = r2[23:0];
          quo_d = {quo_d[QUO_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k] <= rem_d;
      dsr_q[k] <= dsr_in;
      quo_q[k] <= quo_d;
    end
  end

  assign m_o = {1'b1, quo_q[DIV_STAGES-1], (rem_q[DIV_STAGES-1] != '0)};

endmodule

[hdl/sfau_norm.sv]
// Normalise and round: leading-zero count, left shift, round to nearest even, pack.
// Depends on sfau_pkg.
module sfau_norm (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  sfau_pkg::mid_t  mid_i,
  output logic            valid_o,
  output sfau_pkg::word_t res_o,
  output logic [1:0]      ord_o
);
  import sfau_pkg::*;

  mid_t        a_q, b_d, b_q;
  logic [4:0]  lz_d, lz_q;
  logic        zero_d, zero_q;
  logic        va_q, vb_q, vc_q;
  word_t       res_d, res_q;
  ord_e        ord_d, ord_q;
  logic [23:0] qm;
  logic [7:0]  low;
  logic        up;
  logic [24:0] qi;
  sexp_t       exr;

  always_comb begin
    lz_d = '0;
    for (int i = 0; i < 32; i++) begin
      if (mid_i.m[i]) begin
        lz_d = 5'(31 - i);
      end
    end
  end

  always_comb begin
    b_d    = a_q;
    b_d.m  = a_q.m << lz_q;
    b_d.e0 = a_q.e0 - sexp_t'({6'b0, lz_q});
    zero_d = (a_q.m == '0);
  end

  always_comb begin
    qm    = b_q.m[31:8];
    low   = b_q.m[7:0];
    up    = (low > 8'h80) || (low == 8'h80 && qm[0]);
    qi    = {1'b0, qm} + {24'b0, up};
    exr   = b_q.e0 + sexp_t'({10'b0, qi[24]});
    ord_d = ORD_LESS;
    if (b_q.kind == K_DIRECT) begin
      res_d = b_q.res;
      ord_d = b_q.ord;
    end else if (zero_q) begin
      res_d = '0;
    end else if (exr >= sexp_t'(255)) begin
      res_d = {b_q.sign, EXP_ALL[30:0]};
    end else if (exr <= sexp_t'(0)) begin
      res_d = {b_q.sign, 31'b0};
    end else begin
      res_d = {b_q.sign, exr[7:0], qi[22:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= mid_i;
    lz_q   <= lz_d;
    b_q    <= b_d;
    zero_q <= zero_d;
    res_q  <= res_d;
    ord_q  <= ord_d;
  end

  assign valid_o = vc_q;
  assign res_o   = res_q;
  assign ord_o   = ord_q;

endmodule
